FILE: src/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

  // Field and datapath widths
  localparam int DW  = 40;        // Q24.16 field width
  localparam int OW  = DW + 1;    // signed operand width (holds a difference)
  localparam int MW  = OW;        // operand magnitude width
  localparam int PW  = 2 * MW;    // product width
  localparam int QW  = 43;        // quotient magnitude bits kept
  localparam int QRW = QW + 1;    // signed quotient width
  localparam int SIW = QRW + 2;   // width of sums ahead of saturation
  localparam int CW  = 17;        // raw count width

  // Saturated quotient magnitude; anything at or beyond this clips all users
  localparam logic [QW-1:0] QSAT = QW'(1) << (QW - 1);

  // Fixed constants
  localparam logic signed [OW-1:0] ONE_Q = OW'(65536);
  localparam logic signed [OW-1:0] PCT   = OW'(100);
  localparam logic signed [OW-1:0] PCT_Q = OW'(6553600);

  // Saturation limits
  localparam logic signed [SIW-1:0] SAT40_HI = SIW'(64'sd549755813887);
  localparam logic signed [SIW-1:0] SAT40_LO = SIW'(-64'sd549755813888);
  localparam logic signed [SIW-1:0] SAT17_HI = SIW'(64'sd65535);
  localparam logic signed [SIW-1:0] SAT17_LO = SIW'(-64'sd65536);

  // Request kinds
  localparam logic [1:0] REQ_MEAS = 2'd0;
  localparam logic [1:0] REQ_CURR = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE_ZERO = 2'd1;
  localparam logic [1:0] ST_CUR_ZERO  = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_CUR_LO = 2'd0;
  localparam logic [1:0] CFG_CUR_HI = 2'd1;
  localparam logic [1:0] CFG_RNG_LO = 2'd2;
  localparam logic [1:0] CFG_RNG_HI = 2'd3;

  // Multiply cell state
  typedef struct packed {
    logic [MW-1:0] a;
    logic [MW-1:0] b;
    logic [PW-1:0] acc;
    logic [MW-1:0] ud;
    logic          neg;
  } acs_mul_t;

  // Divide cell state
  typedef struct packed {
    logic [PW-1:0] dvd;
    logic [MW-1:0] rem;
    logic [QW-1:0] q;
    logic          ovf;
    logic [MW-1:0] ud;
    logic          neg;
  } acs_div_t;

  function automatic logic signed [DW-1:0] sat40(input logic signed [SIW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > SAT40_HI) begin
      r = SAT40_HI[DW-1:0];
    end else if (v < SAT40_LO) begin
      r = SAT40_LO[DW-1:0];
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat17(input logic signed [SIW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT17_HI) begin
      r = SAT17_HI[CW-1:0];
    end else if (v < SAT17_LO) begin
      r = SAT17_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/acs_mul_cell.sv
`timescale 1ns / 1ps

module acs_mul_cell #(
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_i,
  input  acs_pkg::acs_mul_t   st_i,
  input  logic [SW-1:0]       sb_i,
  output logic                vld_o,
  output acs_pkg::acs_mul_t   st_o,
  output logic [SW-1:0]       sb_o
);

  logic              vld_r;
  acs_pkg::acs_mul_t st_r;
  acs_pkg::acs_mul_t st_nxt;
  logic [SW-1:0]     sb_r;

  // Shift in one multiplier bit, MSB first
  always_comb begin
    st_nxt     = st_i;
    st_nxt.b   = st_i.b << 1;
    st_nxt.acc = (st_i.acc << 1) +
                 (st_i.b[acs_pkg::MW-1] ? acs_pkg::PW'(st_i.a) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
      sb_r <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
  assign sb_o  = sb_r;

endmodule

FILE: src/acs_div_cell.sv
`timescale 1ns / 1ps

module acs_div_cell #(
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_i,
  input  acs_pkg::acs_div_t   st_i,
  input  logic [SW-1:0]       sb_i,
  output logic                vld_o,
  output acs_pkg::acs_div_t   st_o,
  output logic [SW-1:0]       sb_o
);

  logic              vld_r;
  acs_pkg::acs_div_t st_r;
  acs_pkg::acs_div_t st_nxt;
  logic [SW-1:0]     sb_r;
  logic [acs_pkg::MW:0] t;
  logic [acs_pkg::MW:0] diff;
  logic                 ge;

  // One restoring step: bring in a dividend bit, subtract when it fits
  always_comb begin
    t      = {st_i.rem, st_i.dvd[acs_pkg::PW-1]};
    diff   = t - {1'b0, st_i.ud};
    ge     = (t >= {1'b0, st_i.ud});
    st_nxt = st_i;
    st_nxt.dvd = st_i.dvd << 1;
    st_nxt.rem = ge ? diff[acs_pkg::MW-1:0] : t[acs_pkg::MW-1:0];
    st_nxt.q   = {st_i.q[acs_pkg::QW-2:0], ge};
    st_nxt.ovf = st_i.ovf | st_i.q[acs_pkg::QW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
      sb_r <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
  assign sb_o  = sb_r;

endmodule

FILE: src/acs_muldiv.sv
`timescale 1ns / 1ps

module acs_muldiv #(
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  vld_i,
  input  logic signed [acs_pkg::OW-1:0]         a_i,
  input  logic signed [acs_pkg::OW-1:0]         b_i,
  input  logic signed [acs_pkg::OW-1:0]         d_i,
  input  logic [SW-1:0]                         sb_i,
  output logic                                  vld_o,
  output logic signed [acs_pkg::QRW-1:0]        q_o,
  output logic [SW-1:0]                         sb_o
);

  localparam int MW = acs_pkg::MW;
  localparam int PW = acs_pkg::PW;
  localparam int NC = MW + PW;

  logic [NC:0]       vld_c;
  logic [SW-1:0]     sb_c [0:NC];
  acs_pkg::acs_mul_t mul_c [0:MW];
  acs_pkg::acs_div_t div_c [0:PW];
  logic [acs_pkg::QW-1:0] mag;

  // Split operands into sign and magnitude
  always_comb begin
    mul_c[0].a   = a_i[acs_pkg::OW-1] ? MW'(-a_i) : MW'(a_i);
    mul_c[0].b   = b_i[acs_pkg::OW-1] ? MW'(-b_i) : MW'(b_i);
    mul_c[0].ud  = d_i[acs_pkg::OW-1] ? MW'(-d_i) : MW'(d_i);
    mul_c[0].acc = '0;
    mul_c[0].neg = a_i[acs_pkg::OW-1] ^ b_i[acs_pkg::OW-1] ^ d_i[acs_pkg::OW-1];
  end

  assign vld_c[0] = vld_i;
  assign sb_c[0]  = sb_i;

  genvar k;
  generate
    for (k = 0; k < MW; k++) begin : g_mul
      acs_mul_cell #(.SW(SW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld_i (vld_c[k]),
        .st_i  (mul_c[k]),
        .sb_i  (sb_c[k]),
        .vld_o (vld_c[k+1]),
        .st_o  (mul_c[k+1]),
        .sb_o  (sb_c[k+1])
      );
    end
  endgenerate

  // Hand the product to the divide row
  always_comb begin
    div_c[0].dvd = mul_c[MW].acc;
    div_c[0].rem = '0;
    div_c[0].q   = '0;
    div_c[0].ovf = 1'b0;
    div_c[0].ud  = mul_c[MW].ud;
    div_c[0].neg = mul_c[MW].neg;
  end

  genvar j;
  generate
    for (j = 0; j < PW; j++) begin : g_div
      acs_div_cell #(.SW(SW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld_i (vld_c[MW+j]),
        .st_i  (div_c[j]),
        .sb_i  (sb_c[MW+j]),
        .vld_o (vld_c[MW+j+1]),
        .st_o  (div_c[j+1]),
        .sb_o  (sb_c[MW+j+1])
      );
    end
  endgenerate

  // Clip the magnitude and restore the sign
  assign mag   = div_c[PW].ovf ? acs_pkg::QSAT : div_c[PW].q;
  assign q_o   = div_c[PW].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign vld_o = vld_c[NC];
  assign sb_o  = sb_c[NC];

endmodule

FILE: src/analog_channel_scaler.sv
// Analog channel scaler: converts one channel value between engineering
// units, loop current and raw converter count along the line set by the
// current limits and the measured range (signed Q24.16 in 40 bits; the raw
// count output is a signed 17-bit integer). Input beats carry a request kind
// and a value; every input beat gives one result beat with status, all three
// forms, slope, offset, percentages and an out-of-scale flag. The user must
// write registers through cfg_wr_en/cfg_index/cfg_wdata only while no beat
// is in flight; the block does not enforce this. Throughput: one beat per
// cycle while not stalled. A beat passes three dependent multiply-divide
// rows of 123 cells each (41 multiply cells, 82 restoring divide cells) plus
// four register stages. Reset clears all valid bits and loads default limits
// (4 mA, 20 mA, 0.0, 100.0). While out_valid is high and out_stall is high,
// the whole pipeline holds and in_stall is raised; nothing is dropped.
`timescale 1ns / 1ps

module analog_channel_scaler #(
  parameter int RAW_FULL_SCALE = 4095
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [39:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic signed [39:0]  in_input_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [39:0]  out_measured,
  output logic signed [39:0]  out_current_ma,
  output logic signed [39:0]  out_bias,
  output logic signed [39:0]  out_scale,
  output logic signed [16:0]  out_raw_count,
  output logic signed [39:0]  out_range_percent,
  output logic signed [39:0]  out_raw_percent,
  output logic                out_out_of_scale
);

  localparam int DW  = acs_pkg::DW;
  localparam int OW  = acs_pkg::OW;
  localparam int QRW = acs_pkg::QRW;
  localparam int SIW = acs_pkg::SIW;
  localparam int CW  = acs_pkg::CW;

  localparam logic signed [OW-1:0] RFS_O   = OW'(RAW_FULL_SCALE);
  localparam logic signed [OW-1:0] RAW_DIV = OW'(RAW_FULL_SCALE) <<< 16;
  localparam logic signed [CW-1:0] RFS_C   = CW'(RAW_FULL_SCALE);

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [DW-1:0] x;
  } sba_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] cur;
    logic signed [DW-1:0] scale;
    logic signed [DW-1:0] bias;
  } sbb_t;

  typedef struct packed {
    logic signed [DW-1:0] meas;
    logic signed [DW-1:0] cur;
    logic signed [DW-1:0] scale;
    logic signed [DW-1:0] bias;
    logic signed [CW-1:0] raw;
  } sbc_t;

  // Configuration and derived spans
  logic signed [DW-1:0] cur_lo_r, cur_hi_r, rng_lo_r, rng_hi_r;
  logic signed [OW-1:0] rs_r, cs_r;
  logic signed [DW-1:0] cmin, cmax;

  logic adv;

  // Entry stage
  logic                 s0_vld_r;
  logic [1:0]           s0_mode_r;
  logic signed [DW-1:0] s0_x_r;

  // Row A
  logic signed [OW-1:0]  a1_op, d1_op;
  sba_t                  sba_in, sba_out;
  logic                  a_vld;
  logic signed [QRW-1:0] q1, qs, qb;

  // Stage 1 and row B
  logic                 s1_vld_r;
  sbb_t                 s1_r;
  logic signed [OW-1:0] b_op;
  sbb_t                 sbb_out;
  logic                 b_vld;
  logic signed [QRW-1:0] qm, qr;

  // Stage 2 and row C
  logic                 s2_vld_r;
  sbc_t                 s2_r;
  logic signed [OW-1:0] cm_op, cr_op;
  sbc_t                 sbc_out;
  logic                 c_vld;
  logic signed [QRW-1:0] qp, qw;

  // Output register
  logic                 out_valid_r;
  logic [1:0]           status_r;
  logic signed [DW-1:0] meas_r, cur_r, bias_r, scale_r, rpct_r, wpct_r;
  logic signed [CW-1:0] raw_r;
  logic                 oos_r;
  logic [1:0]           status_nxt;

  // Hold the pipeline while the result beat is stalled
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_lo_r <= 40'sd262144;
      cur_hi_r <= 40'sd1310720;
      rng_lo_r <= 40'sd0;
      rng_hi_r <= 40'sd6553600;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        acs_pkg::CFG_CUR_LO: cur_lo_r <= cfg_wdata;
        acs_pkg::CFG_CUR_HI: cur_hi_r <= cfg_wdata;
        acs_pkg::CFG_RNG_LO: rng_lo_r <= cfg_wdata;
        acs_pkg::CFG_RNG_HI: rng_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Track spans from the registers
  always_ff @(posedge clk) begin
    rs_r <= OW'(rng_hi_r) - OW'(rng_lo_r);
    cs_r <= OW'(cur_hi_r) - OW'(cur_lo_r);
  end

  assign cmin = (cur_lo_r < cur_hi_r) ? cur_lo_r : cur_hi_r;
  assign cmax = (cur_lo_r < cur_hi_r) ? cur_hi_r : cur_lo_r;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mode_r <= in_req_type;
      s0_x_r    <= in_input_value;
    end
  end

  // Row A: current from value or count, plus slope and offset terms
  assign a1_op = (s0_mode_r == acs_pkg::REQ_MEAS) ? OW'(s0_x_r) - OW'(rng_lo_r)
                                                  : OW'(s0_x_r);
  assign d1_op = (s0_mode_r == acs_pkg::REQ_MEAS) ? rs_r : RAW_DIV;
  assign sba_in = '{mode: s0_mode_r, x: s0_x_r};

  acs_muldiv #(.SW($bits(sba_t))) u_cur_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s0_vld_r),
    .a_i (a1_op), .b_i (cs_r), .d_i (d1_op), .sb_i (sba_in),
    .vld_o (a_vld), .q_o (q1), .sb_o (sba_out)
  );

  acs_muldiv #(.SW(1)) u_scale_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s0_vld_r),
    .a_i (rs_r), .b_i (acs_pkg::ONE_Q), .d_i (cs_r), .sb_i (1'b0),
    .vld_o (), .q_o (qs), .sb_o ()
  );

  acs_muldiv #(.SW(1)) u_bias_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s0_vld_r),
    .a_i (rs_r), .b_i (OW'(cur_lo_r)), .d_i (cs_r), .sb_i (1'b0),
    .vld_o (), .q_o (qb), .sb_o ()
  );

  // Stage 1: resolve current, slope and offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.mode  <= sba_out.mode;
      s1_r.x     <= sba_out.x;
      s1_r.cur   <= (sba_out.mode == acs_pkg::REQ_CURR) ? sba_out.x :
                    acs_pkg::sat40(SIW'(q1) + SIW'(cur_lo_r));
      s1_r.scale <= acs_pkg::sat40(SIW'(qs));
      s1_r.bias  <= acs_pkg::sat40(SIW'(rng_lo_r) - SIW'(qb));
    end
  end

  // Row B: measured value and raw count from current
  assign b_op = OW'(s1_r.cur) - OW'(cur_lo_r);

  acs_muldiv #(.SW($bits(sbb_t))) u_meas_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s1_vld_r),
    .a_i (b_op), .b_i (rs_r), .d_i (cs_r), .sb_i (s1_r),
    .vld_o (b_vld), .q_o (qm), .sb_o (sbb_out)
  );

  acs_muldiv #(.SW(1)) u_raw_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s1_vld_r),
    .a_i (b_op), .b_i (RFS_O), .d_i (cs_r), .sb_i (1'b0),
    .vld_o (), .q_o (qr), .sb_o ()
  );

  // Stage 2: resolve measured value and raw count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.meas  <= (sbb_out.mode == acs_pkg::REQ_MEAS) ? sbb_out.x :
                    acs_pkg::sat40(SIW'(qm) + SIW'(rng_lo_r));
      s2_r.cur   <= sbb_out.cur;
      s2_r.scale <= sbb_out.scale;
      s2_r.bias  <= sbb_out.bias;
      s2_r.raw   <= acs_pkg::sat17(SIW'(qr));
    end
  end

  // Row C: percentages
  assign cm_op = OW'(s2_r.meas) - OW'(rng_lo_r);
  assign cr_op = OW'(s2_r.raw);

  acs_muldiv #(.SW($bits(sbc_t))) u_rpct_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s2_vld_r),
    .a_i (cm_op), .b_i (acs_pkg::PCT), .d_i (rs_r), .sb_i (s2_r),
    .vld_o (c_vld), .q_o (qp), .sb_o (sbc_out)
  );

  acs_muldiv #(.SW(1)) u_wpct_div (
    .clk (clk), .rst_n (rst_n), .adv (adv), .vld_i (s2_vld_r),
    .a_i (cr_op), .b_i (acs_pkg::PCT_Q), .d_i (RFS_O), .sb_i (1'b0),
    .vld_o (), .q_o (qw), .sb_o ()
  );

  // Zero spans override the whole result
  always_comb begin
    if (rs_r == '0) begin
      status_nxt = acs_pkg::ST_RANGE_ZERO;
    end else if (cs_r == '0) begin
      status_nxt = acs_pkg::ST_CUR_ZERO;
    end else begin
      status_nxt = acs_pkg::ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      if (status_nxt != acs_pkg::ST_OK) begin
        meas_r  <= '0;
        cur_r   <= '0;
        bias_r  <= '0;
        scale_r <= '0;
        raw_r   <= '0;
        rpct_r  <= '0;
        wpct_r  <= '0;
        oos_r   <= 1'b0;
      end else begin
        meas_r  <= sbc_out.meas;
        cur_r   <= sbc_out.cur;
        bias_r  <= sbc_out.bias;
        scale_r <= sbc_out.scale;
        raw_r   <= sbc_out.raw;
        rpct_r  <= acs_pkg::sat40(SIW'(qp));
        wpct_r  <= acs_pkg::sat40(SIW'(qw));
        oos_r   <= (sbc_out.cur < cmin) || (sbc_out.cur > cmax) ||
                   (sbc_out.raw < 0) || (sbc_out.raw > RFS_C);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_measured      = meas_r;
  assign out_current_ma    = cur_r;
  assign out_bias          = bias_r;
  assign out_scale         = scale_r;
  assign out_raw_count     = raw_r;
  assign out_range_percent = rpct_r;
  assign out_raw_percent   = wpct_r;
  assign out_out_of_scale  = oos_r;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // An error status carries zeroed fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != acs_pkg::ST_OK) |->
      (out_measured == 0 && out_current_ma == 0 && out_raw_count == 0 &&
       out_scale == 0 && !out_out_of_scale))
    else $error("error status with nonzero fields");

  // A count beyond full scale must be flagged
  a_raw_oos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == acs_pkg::ST_OK &&
     (out_raw_count < 0 || out_raw_count > RFS_C)) |-> out_out_of_scale)
    else $error("raw count out of range but not flagged");

  // A current beyond the limits must be flagged
  a_cur_oos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == acs_pkg::ST_OK &&
     (out_current_ma < cmin || out_current_ma > cmax)) |-> out_out_of_scale)
    else $error("current outside limits but not flagged");

endmodule
